// File: rtl/fpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpe_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SQ_WIDTH   = 2 * WORD_WIDTH + 2;
    localparam int NUM_WIDTH  = WORD_WIDTH + FRAC_BITS;

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_EXTRACT = 2'd1;
    localparam logic [1:0] REQ_TEST    = 2'd2;

    localparam word_t WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_EX_LOAD, ST_EX_SQ, ST_EX_SQRT, ST_EX_DIV, ST_EX_STORE,
        ST_PT_MUL, ST_PT_ACC, ST_PT_ADDW, ST_RESP
    } state_t;

    function automatic word_t sat_wide(input logic signed [WORD_WIDTH+1:0] v);
        if (v > $signed({2'b00, WMAX})) return WMAX;
        if (v < $signed({2'b11, WMIN})) return WMIN;
        return v[WORD_WIDTH-1:0];
    endfunction

    function automatic word_t from_mag(input logic [NUM_WIDTH-1:0] m, input logic neg);
        if (neg) begin
            if (m >= NUM_WIDTH'({1'b0, WMAX}) + NUM_WIDTH'(1)) return WMIN;
            return word_t'(-m[WORD_WIDTH-1:0]);
        end
        if (m > NUM_WIDTH'({1'b0, WMAX})) return WMAX;
        return m[WORD_WIDTH-1:0];
    endfunction

    function automatic logic [WORD_WIDTH-1:0] mag(input word_t a);
        return a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
    endfunction
endpackage
`default_nettype wire

// File: rtl/fpe_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared bit-serial unit: floor sqrt of sum of squares, or (m << FRAC_BITS) / d.
module fpe_divsqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             do_sqrt,
    input  wire logic [fpe_pkg::SQ_WIDTH-1:0]     operand,
    input  wire logic [fpe_pkg::WORD_WIDTH-1:0]   divisor,
    output logic                                  done,
    output logic [fpe_pkg::NUM_WIDTH-1:0]         result
);
    import fpe_pkg::*;
    localparam int CW = $clog2(SQ_WIDTH + 1);

    logic                  busy_reg, busy_next, sqrt_reg, sqrt_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [SQ_WIDTH-1:0]   src_reg, src_next;
    logic [SQ_WIDTH+1:0]   rem_reg, rem_next;
    logic [NUM_WIDTH-1:0]  q_reg, q_next;
    logic [WORD_WIDTH-1:0] d_reg, d_next;
    logic [SQ_WIDTH+1:0]   trial, rsh;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        sqrt_reg <= sqrt_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        done      = 1'b0;
        rsh       = '0;
        trial     = '0;
        if (start) begin
            busy_next = 1'b1;
            sqrt_next = do_sqrt;
            src_next  = operand;
            rem_next  = '0;
            q_next    = '0;
            d_next    = divisor;
            cnt_next  = do_sqrt ? CW'(SQ_WIDTH / 2) : CW'(NUM_WIDTH);
        end else if (busy_reg) begin
            if (sqrt_reg) begin
                // restoring root: two bits of radicand per step
                rsh   = {rem_reg[SQ_WIDTH-1:0], src_reg[SQ_WIDTH-1 -: 2]};
                trial = {q_reg, 2'b01};
                src_next = {src_reg[SQ_WIDTH-3:0], 2'b00};
                if (rsh >= trial) begin
                    rem_next = rsh - trial;
                    q_next   = {q_reg[NUM_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = rsh;
                    q_next   = {q_reg[NUM_WIDTH-2:0], 1'b0};
                end
            end else begin
                rsh   = {rem_reg[SQ_WIDTH:0], src_reg[NUM_WIDTH-1]};
                trial = (SQ_WIDTH+2)'(d_reg);
                src_next = {src_reg[SQ_WIDTH-2:0], 1'b0};
                if (rsh >= trial) begin
                    rem_next = rsh - trial;
                    q_next   = {q_reg[NUM_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = rsh;
                    q_next   = {q_reg[NUM_WIDTH-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign result = q_next;
endmodule
`default_nettype wire

// File: rtl/frustum_plane_extract_and_point_test.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | ports
// request | in        | req_valid req_ready req_type elem_index elem_value point_x/y/z
// response| out       | resp_valid resp_ready resp_kind inside_res
// Matrix write: no response. Point test: 6 planes, each 3 multiply/accumulate pairs plus
// the w add, on one multiplier. Extract: six planes, each a load, the x/y/z squares,
// a 33-step root and four divides (none for a zero length) in the shared divide/root
// unit, plus four stores.
// Reset zeroes matrix and planes. Request ready only in idle; a held response stalls.
module frustum_plane_extract_and_point_test (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [1:0]                        req_type,
    input  wire logic [3:0]                        elem_index,
    input  wire logic signed [31:0]                elem_value,
    input  wire logic signed [31:0]                point_x,
    input  wire logic signed [31:0]                point_y,
    input  wire logic signed [31:0]                point_z,
    output logic                                   resp_valid,
    input  wire logic                              resp_ready,
    output logic                                   resp_kind,
    output logic                                   inside_res
);
    import fpe_pkg::*;

    state_t state_reg, state_next;
    word_t  mat_reg [16];
    word_t  pl_reg [24];
    word_t  pt_reg [3];
    word_t  cur_reg [4], cur_next [4];
    logic [2:0] plane_reg, plane_next;
    logic [1:0] comp_reg, comp_next;
    logic [SQ_WIDTH-1:0] acc_reg, acc_next;
    word_t  sacc_reg, sacc_next;
    logic [2*WORD_WIDTH-1:0] prod_reg, prod_next;
    logic [WORD_WIDTH-1:0] len_reg, len_next;
    logic   kind_reg, kind_next, ins_reg, ins_next, rv_reg, rv_next;
    logic   du_start, du_sqrt, du_done;
    logic [NUM_WIDTH-1:0] du_res;
    logic [SQ_WIDTH-1:0]  du_op;
    logic   pl_we, wr_en;
    logic [4:0] pl_wa;
    word_t  pl_wd;
    logic [1:0] col;
    logic [WORD_WIDTH-1:0] ma, mb;
    logic [2*WORD_WIDTH-1:0] mp;
    logic [2*WORD_WIDTH-FRAC_BITS-1:0] sh;
    word_t  fm;

    fpe_divsqrt u_du (
        .clk(clk), .rst_n(rst_n), .start(du_start), .do_sqrt(du_sqrt),
        .operand(du_op), .divisor(len_reg), .done(du_done), .result(du_res)
    );

    assign req_ready  = (state_reg == ST_IDLE) && !rv_reg;
    assign resp_valid = rv_reg;
    assign resp_kind  = kind_reg;
    assign inside_res = ins_reg;
    assign wr_en = req_valid && req_ready && (req_type == REQ_WRITE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
            for (int i = 0; i < 24; i++) pl_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            if (wr_en) mat_reg[elem_index] <= elem_value;
            if (pl_we) pl_reg[pl_wa] <= pl_wd;
        end
    end

    always_ff @(posedge clk) begin
        plane_reg <= plane_next;
        comp_reg  <= comp_next;
        acc_reg   <= acc_next;
        sacc_reg  <= sacc_next;
        prod_reg  <= prod_next;
        len_reg   <= len_next;
        kind_reg  <= kind_next;
        ins_reg   <= ins_next;
        for (int i = 0; i < 4; i++) cur_reg[i] <= cur_next[i];
        if (req_valid && req_ready && req_type == REQ_TEST) begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
        end
    end

    // shared multiplier on magnitudes
    always_comb begin
        if (state_reg == ST_EX_SQ) begin
            ma = mag(cur_reg[comp_reg]);
            mb = ma;
        end else begin
            ma = mag(pt_reg[comp_reg]);
            mb = mag(pl_reg[{plane_reg, comp_reg}]);
        end
        mp = ma * mb;
    end

    assign sh = prod_reg[2*WORD_WIDTH-1:FRAC_BITS];
    assign fm = from_mag(sh,
                         pt_reg[comp_reg][WORD_WIDTH-1] ^ pl_reg[{plane_reg, comp_reg}][WORD_WIDTH-1]);
    assign col = plane_reg[2:1];

    always_comb begin
        state_next = state_reg;
        plane_next = plane_reg;
        comp_next  = comp_reg;
        acc_next   = acc_reg;
        sacc_next  = sacc_reg;
        prod_next  = mp;
        len_next   = len_reg;
        kind_next  = kind_reg;
        ins_next   = ins_reg;
        rv_next    = rv_reg;
        for (int i = 0; i < 4; i++) cur_next[i] = cur_reg[i];
        du_start = 1'b0;
        du_sqrt  = 1'b0;
        du_op    = '0;
        pl_we    = 1'b0;
        pl_wa    = '0;
        pl_wd    = '0;
        if (rv_reg && resp_ready) rv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid && req_ready) begin
                    plane_next = '0;
                    comp_next  = '0;
                    if (req_type == REQ_EXTRACT) begin
                        state_next = ST_EX_LOAD;
                    end else if (req_type == REQ_TEST) begin
                        sacc_next  = '0;
                        ins_next   = 1'b1;
                        state_next = ST_PT_MUL;
                    end
                end
            end
            ST_EX_LOAD: begin
                for (int k = 0; k < 4; k++) begin
                    if (plane_reg[0])
                        cur_next[k] = sat_wide($signed({{2{mat_reg[k*4+3][WORD_WIDTH-1]}},
                            mat_reg[k*4+3]}) - $signed({{2{mat_reg[k*4+col][WORD_WIDTH-1]}},
                            mat_reg[k*4+col]}));
                    else
                        cur_next[k] = sat_wide($signed({{2{mat_reg[k*4+3][WORD_WIDTH-1]}},
                            mat_reg[k*4+3]}) + $signed({{2{mat_reg[k*4+col][WORD_WIDTH-1]}},
                            mat_reg[k*4+col]}));
                end
                acc_next   = '0;
                comp_next  = '0;
                state_next = ST_EX_SQ;
            end
            ST_EX_SQ: begin
                // one square per cycle, summed (product lands next cycle)
                if (comp_reg != 2'd0)
                    acc_next = acc_reg + SQ_WIDTH'(prod_reg);
                if (comp_reg == 2'd3) begin
                    du_start   = 1'b1;
                    du_sqrt    = 1'b1;
                    du_op      = acc_reg + SQ_WIDTH'(prod_reg);
                    state_next = ST_EX_SQRT;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_EX_SQRT: begin
                if (du_done) begin
                    len_next  = du_res[WORD_WIDTH-1:0];
                    comp_next = '0;
                    // acc_reg bit 0 marks a divide in flight
                    acc_next  = '0;
                    if (du_res == '0) begin
                        // zero length: xyz are already zero, only w is cleared
                        cur_next[3] = '0;
                        state_next  = ST_EX_STORE;
                    end else begin
                        state_next = ST_EX_DIV;
                    end
                end
            end
            ST_EX_DIV: begin
                if (!du_start && comp_reg[1:0] == comp_reg && acc_reg[0] == 1'b0) begin
                    du_start = 1'b1;
                    du_op    = SQ_WIDTH'({mag(cur_reg[comp_reg]), {FRAC_BITS{1'b0}}});
                    acc_next = SQ_WIDTH'(1);
                end else if (du_done) begin
                    cur_next[comp_reg] = from_mag(du_res, cur_reg[comp_reg][WORD_WIDTH-1]);
                    acc_next = '0;
                    if (comp_reg == 2'd3) begin
                        comp_next  = '0;
                        state_next = ST_EX_STORE;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            ST_EX_STORE: begin
                pl_we = 1'b1;
                pl_wa = 5'({plane_reg, 2'b00}) + 5'(comp_reg);
                pl_wd = cur_reg[comp_reg];
                if (comp_reg == 2'd3) begin
                    if (plane_reg == 3'd5) begin
                        kind_next  = 1'b0;
                        ins_next   = 1'b0;
                        rv_next    = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        plane_next = plane_reg + 3'd1;
                        state_next = ST_EX_LOAD;
                    end
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_PT_MUL: begin
                state_next = ST_PT_ACC;
            end
            ST_PT_ACC: begin
                sacc_next = (comp_reg == 2'd0) ? fm
                    : sat_wide($signed({{2{sacc_reg[WORD_WIDTH-1]}}, sacc_reg})
                             + $signed({{2{fm[WORD_WIDTH-1]}}, fm}));
                if (comp_reg == 2'd2) begin
                    comp_next  = 2'd3;
                    state_next = ST_PT_ADDW;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_PT_MUL;
                end
            end
            ST_PT_ADDW: begin
                sacc_next = sat_wide($signed({{2{sacc_reg[WORD_WIDTH-1]}}, sacc_reg})
                    + $signed({{2{pl_reg[{plane_reg, 2'd3}][WORD_WIDTH-1]}},
                               pl_reg[{plane_reg, 2'd3}]}));
                if (sacc_next[WORD_WIDTH-1]) ins_next = 1'b0;
                comp_next = '0;
                if (plane_reg == 3'd5) begin
                    kind_next  = 1'b1;
                    rv_next    = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    plane_next = plane_reg + 3'd1;
                    state_next = ST_PT_MUL;
                end
            end
            ST_RESP: begin
                if (!rv_next) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: tb/sv/frustum_plane_extract_and_point_test_tb.sv
`timescale 1ns / 1ps
module frustum_plane_extract_and_point_test_tb;
    import fpe_pkg::*;

    localparam int ROOT_STEP = 1 << 16;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    class frustum_scoreboard;
        longint matrix[16];
        longint plane[24];
        bit     kind_q[$];
        bit     inside_q[$];
        int     errors;

        function new();
            foreach (matrix[i]) matrix[i] = 0;
            foreach (plane[i]) plane[i] = 0;
            errors = 0;
        endfunction

        function longint clampw(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            logic signed [127:0] p;
            logic [127:0] m;
            bit neg;
            p = 128'(a) * 128'(b);
            neg = p < 0;
            m = neg ? -p : p;
            m = m >> FRAC_BITS;
            if (neg) return (m >= 128'd2147483648) ? -64'sd2147483648 : -longint'(m);
            return (m > 128'd2147483647) ? 64'sd2147483647 : longint'(m);
        endfunction

        function longint isqrt(logic [127:0] v);
            logic [127:0] r;
            logic [127:0] c;
            r = 0;
            for (int b = 63; b >= 0; b--)
            begin
                c = r | (128'd1 << b);
                if (c * c <= v) r = c;
            end
            return longint'(r);
        endfunction

        function void normalize(int base);
            logic [127:0] s;
            logic [127:0] m;
            logic [127:0] q;
            longint len;
            bit neg;
            s = 0;
            for (int k = 0; k < 3; k++)
                s += 128'(plane[base+k] * plane[base+k]);
            len = isqrt(s);
            if (len == 0)
            begin
                plane[base+3] = 0;
                return;
            end
            for (int k = 0; k < 4; k++)
            begin
                neg = plane[base+k] < 0;
                m = neg ? 128'(-plane[base+k]) : 128'(plane[base+k]);
                q = (m << FRAC_BITS) / 128'(len);
                if (neg) plane[base+k] = (q >= 128'd2147483648) ? -64'sd2147483648 : -longint'(q);
                else plane[base+k] = (q > 128'd2147483647) ? 64'sd2147483647 : longint'(q);
            end
        endfunction

        function void note_request(logic [1:0] t, logic [3:0] idx, word_t v,
                                   word_t px, word_t py, word_t pz);
            longint acc;
            bit ok;
            case (t)
                REQ_WRITE: matrix[idx] = longint'(v);
                REQ_EXTRACT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            plane[8*i+k]   = clampw(matrix[k*4+3] + matrix[k*4+i]);
                            plane[8*i+4+k] = clampw(matrix[k*4+3] - matrix[k*4+i]);
                        end
                        normalize(8*i);
                        normalize(8*i+4);
                    end
                    kind_q.push_back(1'b0);
                    inside_q.push_back(1'b0);
                end
                REQ_TEST:
                begin
                    ok = 1;
                    for (int i = 0; i < 6; i++)
                    begin
                        acc = qmul(px, plane[4*i]);
                        acc = clampw(acc + qmul(py, plane[4*i+1]));
                        acc = clampw(acc + qmul(pz, plane[4*i+2]));
                        acc = clampw(acc + plane[4*i+3]);
                        if (acc < 0) ok = 0;
                    end
                    kind_q.push_back(1'b1);
                    inside_q.push_back(ok);
                end
                default: ;
            endcase
        endfunction

        function void check_response(bit kind, bit ins);
            if (kind_q.size() == 0)
            begin
                report_mismatch("response with nothing pending");
                return;
            end
            if (kind != kind_q[0]) report_mismatch("resp_kind mismatch");
            if (ins != inside_q[0]) report_mismatch("inside_res mismatch");
            void'(kind_q.pop_front());
            void'(inside_q.pop_front());
        endfunction

        function void report_mismatch(string what);
            $display("ERROR %0t: %s", $time, what);
            errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic [3:0]  elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        resp_valid;
    logic        resp_ready;
    logic        resp_kind;
    logic        inside_res;

    frustum_scoreboard frustum_sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_resp;
    longint cycle_count;

    frustum_plane_extract_and_point_test i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
        .elem_index(elem_index), .elem_value(elem_value),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .resp_valid(resp_valid), .resp_ready(resp_ready),
        .resp_kind(resp_kind), .inside_res(inside_res)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd20000000)
        begin
            $display("frustum_plane_extract_and_point_test_tb failed");
            $finish;
        end
    end

    // response side: sample at rising edge, drive ready at falling edge
    always @(posedge clk)
    begin
        if (rst_n && resp_valid && resp_ready)
            frustum_sb.check_response(resp_kind, inside_res);
    end

    always @(negedge clk)
    begin
        if (!rst_n) resp_ready <= 1'b0;
        else resp_ready <= !hold_resp && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic word_t rand_word();
        case ($urandom_range(5))
            0: return WMAX;
            1: return WMIN;
            2: return word_t'($urandom_range(131072)) - word_t'(65536);
            3: return word_t'($urandom_range(2097152)) - word_t'(1048576);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic send_request(logic [1:0] t, logic [3:0] idx, word_t v,
                                word_t px, word_t py, word_t pz);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        req_valid = 1'b1;
        req_type = t;
        elem_index = idx;
        elem_value = v;
        point_x = px;
        point_y = py;
        point_z = pz;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        frustum_sb.note_request(t, idx, v, px, py, pz);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic send_write(logic [3:0] idx, word_t v);
        send_request(REQ_WRITE, idx, v, rand_word(), rand_word(), rand_word());
    endtask

    task automatic send_point(word_t px, word_t py, word_t pz);
        send_request(REQ_TEST, 4'($urandom), rand_word(), px, py, pz);
    endtask

    // perspective-like matrix with random perturbation, so points land on both sides
    task automatic load_frustum_matrix();
        for (int i = 0; i < 16; i++)
        begin
            word_t v;
            v = word_t'($urandom_range(2 * ROOT_STEP)) - word_t'(ROOT_STEP);
            if (i == 0 || i == 5 || i == 10 || i == 15 || i == 14) v = v + word_t'(ROOT_STEP);
            if ($urandom_range(19) == 0) v = rand_word();
            send_write(4'(i), v);
        end
    endtask

    task automatic wait_drained();
        while (frustum_sb.kind_q.size() != 0) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(99))
                0, 1:
                begin
                    load_frustum_matrix();
                    send_request(REQ_EXTRACT, 4'($urandom), rand_word(), rand_word(),
                                 rand_word(), rand_word());
                    n += 17;
                end
                2, 3, 4: begin send_write(4'($urandom), rand_word()); n++; end
                5: send_request(REQ_RESERVED, 4'($urandom), rand_word(), rand_word(),
                                rand_word(), rand_word());
                default:
                begin
                    if ($urandom_range(3) == 0)
                        send_point(rand_word(), rand_word(), rand_word());
                    else
                        send_point(word_t'($urandom_range(4 * ROOT_STEP)) - word_t'(2 * ROOT_STEP),
                                   word_t'($urandom_range(4 * ROOT_STEP)) - word_t'(2 * ROOT_STEP),
                                   word_t'($urandom_range(4 * ROOT_STEP)) - word_t'(2 * ROOT_STEP));
                    n++;
                end
            endcase
        end
    endtask

    initial
    begin
        frustum_sb = new();
        cycle_count = 0;
        hold_resp = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = REQ_WRITE;
        elem_index = '0;
        elem_value = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // planes all zero after reset: answer is inside
        send_point(WMAX, WMIN, 32'sd0);
        send_request(REQ_EXTRACT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_point(WMIN, WMIN, WMIN);
        // identity-like clip matrix, extreme and saturating entries
        for (int i = 0; i < 16; i++)
            send_write(4'(i), (i % 5 == 0) ? 32'sd65536 : 32'sd0);
        send_request(REQ_EXTRACT, 4'hf, WMIN, 32'sd0, 32'sd0, 32'sd0);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sd131072, 32'sd0, 32'sd0);
        send_point(WMAX, WMAX, WMAX);
        send_request(REQ_RESERVED, 4'hf, WMAX, WMAX, WMIN, WMAX);
        send_write(4'd3, WMAX);
        send_write(4'd0, WMIN);
        send_write(4'd15, WMAX);
        send_write(4'd12, WMIN);
        send_request(REQ_EXTRACT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_point(WMIN, WMAX, 32'sd1);
        send_point(-32'sd1, -32'sd1, -32'sd1);

        send_idle_pct = 19;
        recv_idle_pct = 71;
        random_phase(700);
        wait_drained();
        // pause on the sender until everything is back, then stall the receiver
        fork
            begin
                hold_resp = 1;
                repeat (3000) @(negedge clk);
                hold_resp = 0;
            end
            begin
                send_idle_pct = 0;
                for (int i = 0; i < 8; i++) send_point(rand_word(), rand_word(), rand_word());
            end
        join
        send_idle_pct = 71;
        recv_idle_pct = 19;
        random_phase(700);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(600);

        wait_drained();
        repeat (2000) @(negedge clk);
        if (frustum_sb.kind_q.size() != 0)
            frustum_sb.report_mismatch("expected responses never arrived");
        if (frustum_sb.errors == 0)
            $display("frustum_plane_extract_and_point_test_tb passed");
        else
            $display("frustum_plane_extract_and_point_test_tb failed");
        $finish;
    end
endmodule

// File: filelist.f
rtl/fpe_pkg.sv
rtl/fpe_divsqrt.sv
rtl/frustum_plane_extract_and_point_test.sv
tb/sv/frustum_plane_extract_and_point_test_tb.sv
